// File: rtl/hsbr_pkg.sv
// ----------------------------------------------------------------------------
// HSB to RGB converter package
// Beat types and the fixed constants shared by the pipeline stages.
// ----------------------------------------------------------------------------
package hsbr_pkg;

  // Input beat: hue, saturation and brightness with 12 fraction bits.
  typedef struct packed {
    logic [11:0] hue;
    logic [12:0] saturation;
    logic [12:0] brightness;
  } hsbr_in_t;

  // Result beat: truncated 8-bit color channels.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsbr_out_t;

  localparam int unsigned IN_FRAC  = 12;
  localparam logic [12:0] IN_ONE   = 13'd4096;
  localparam int unsigned NUM_CHAN = 3;

  // Hue offsets in sixths of a turn for red, green and blue.
  localparam logic [2:0] CHAN_OFFSET [NUM_CHAN] = '{3'd0, 3'd4, 3'd2};

endpackage

// File: rtl/hsbr_prep.sv
// ----------------------------------------------------------------------------
// HSB to RGB input stage
// Clamps saturation and brightness to 1.0, scales hue by six and converts
// all three to the internal fixed-point format.
// ----------------------------------------------------------------------------
module hsbr_prep #(
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  hsbr_pkg::hsbr_in_t       in_pixel,
  output logic                     vld,
  output logic [FRACTION_BITS+2:0] h6,
  output logic [FRACTION_BITS:0]   s,
  output logic [FRACTION_BITS:0]   b
);
  import hsbr_pkg::*;

  localparam int unsigned F = FRACTION_BITS;

  logic [14:0]    hue6;
  logic [F+14:0]  h_wide;
  logic [12:0]    s_clamp;
  logic [12:0]    b_clamp;
  logic [F+12:0]  s_wide;
  logic [F+12:0]  b_wide;

  logic           vld_r;
  logic [F+2:0]   h6_r, h6_nxt;
  logic [F:0]     s_r, s_nxt;
  logic [F:0]     b_r, b_nxt;

  always_comb begin
    hue6    = 15'({in_pixel.hue, 2'b00}) + 15'({in_pixel.hue, 1'b0});
    h_wide  = (F+15)'(hue6) << F;
    h6_nxt  = h_wide[F+14:IN_FRAC];
    s_clamp = (in_pixel.saturation > IN_ONE) ? IN_ONE : in_pixel.saturation;
    b_clamp = (in_pixel.brightness > IN_ONE) ? IN_ONE : in_pixel.brightness;
    s_wide  = (F+13)'(s_clamp) << F;
    b_wide  = (F+13)'(b_clamp) << F;
    s_nxt   = s_wide[F+12:IN_FRAC];
    b_nxt   = b_wide[F+12:IN_FRAC];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    h6_r <= h6_nxt;
    s_r  <= s_nxt;
    b_r  <= b_nxt;
  end

  assign vld = vld_r;
  assign h6  = h6_r;
  assign s   = s_r;
  assign b   = b_r;

endmodule

// File: rtl/hsbr_chan.sv
// ----------------------------------------------------------------------------
// HSB to RGB channel pipeline
// Six stages for one color channel: hue fold and clamp, square, smoothstep,
// saturation mix, brightness scale and conversion to 8 bits.
// ----------------------------------------------------------------------------
module hsbr_chan #(
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [2:0]               offset,
  input  logic                     in_vld,
  input  logic [FRACTION_BITS+2:0] h6,
  input  logic [FRACTION_BITS:0]   s,
  input  logic [FRACTION_BITS:0]   b,
  output logic                     vld,
  output logic [7:0]               value
);
  import hsbr_pkg::*;

  localparam int unsigned F = FRACTION_BITS;
  localparam logic [F+3:0] ONE   = (F+4)'(1) << F;
  localparam logic [F+3:0] TWO   = (F+4)'(2) << F;
  localparam logic [F+3:0] THREE = (F+4)'(3) << F;
  localparam logic [F+3:0] SIX   = (F+4)'(6) << F;

  // Valid bits, one per stage.
  logic [5:0]     vld_r;

  logic [F+3:0]   t_sum, t_mod, d;
  logic [F:0]     x_r, x_nxt;
  logic [2*F+1:0] sq;
  logic [F+3:0]   w_full;
  logic [F:0]     x2_r, x2_nxt;
  logic [F+1:0]   w_r, w_nxt;
  logic [2*F+2:0] pw;
  logic [F:0]     y_r, y_nxt;
  logic [2*F+1:0] sy;
  logic [F+1:0]   mix;
  logic [F:0]     m_r, m_nxt;
  logic [2*F+1:0] mb;
  logic [F+1:0]   vq;
  logic [F:0]     v_r, v_nxt;
  logic [F+8:0]   v255;
  logic [8:0]     q;
  logic [7:0]     value_r, value_nxt;

  // Saturation and brightness ride along until their multiply stages.
  logic [F:0]     s2_r, s3_r, s4_r;
  logic [F:0]     b2_r, b3_r, b4_r, b5_r;

  always_comb begin
    // Fold the hue into the triangle |t - 3| - 1, clamped to [0, 1].
    t_sum = (F+4)'(h6) + ((F+4)'(offset) << F);
    t_mod = (t_sum >= SIX) ? (t_sum - SIX) : t_sum;
    d     = (t_mod >= THREE) ? (t_mod - THREE) : (THREE - t_mod);
    if (d <= ONE) begin
      x_nxt = '0;
    end else if (d >= TWO) begin
      x_nxt = ONE[F:0];
    end else begin
      x_nxt = (F+1)'(d - ONE);
    end

    sq     = x_r * x_r;
    x2_nxt = sq[2*F:F];
    w_full = THREE - ((F+4)'(x_r) << 1);
    w_nxt  = w_full[F+1:0];

    pw    = x2_r * w_r;
    y_nxt = pw[2*F:F];

    // Mix from white toward the pure hue; the sum never exceeds 1.0.
    sy    = s4_r * y_r;
    mix   = (F+2)'(ONE[F:0] - s4_r) + (F+2)'(sy[2*F:F]);
    m_nxt = mix[F:0];

    mb    = m_r * b5_r;
    vq    = mb[2*F+1:F];
    v_nxt = (vq > (F+2)'(ONE)) ? ONE[F:0] : vq[F:0];

    v255      = ((F+9)'(v_r) << 8) - (F+9)'(v_r);
    q         = v255[F+8:F];
    value_nxt = (q > 9'd255) ? 8'd255 : q[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    s2_r    <= s;
    b2_r    <= b;
    x2_r    <= x2_nxt;
    w_r     <= w_nxt;
    s3_r    <= s2_r;
    b3_r    <= b2_r;
    y_r     <= y_nxt;
    s4_r    <= s3_r;
    b4_r    <= b3_r;
    m_r     <= m_nxt;
    b5_r    <= b4_r;
    v_r     <= v_nxt;
    value_r <= value_nxt;
  end

  assign vld   = vld_r[5];
  assign value = value_r;

endmodule

// File: rtl/hsb_to_rgb_smooth_top.sv
// ----------------------------------------------------------------------------
// HSB to RGB converter, smooth cubic hue curve
// Converts one pixel of hue, saturation and brightness into 8-bit RGB.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel beat is taken on in_pixel at each rising edge where start is
//   high and busy is low. busy is always low: the converter is a fully
//   pipelined datapath and takes one pixel every clock cycle.
//   Each result appears on out_pixel for exactly one cycle with out_valid
//   high, after the input register and the six registered stages of its
//   color channel pipeline.
//   Results leave in input order.
//   Throughput is one pixel per cycle; the depth is set by the chain of
//   four registered multiplies per channel (square, smoothstep, saturation
//   mix and brightness scale) plus the fold and output scaling stages.
//   Saturation and brightness above 1.0 (4096) are treated as 1.0.
//   The block holds no state between pixels. A synchronous reset clears
//   the valid bits so no result strobe follows reset; beats in flight are
//   dropped. The receiver cannot stall the output, so there is no
//   backpressure path.
// ----------------------------------------------------------------------------
module hsb_to_rgb_smooth_top #(
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  hsbr_pkg::hsbr_in_t   in_pixel,
  output logic                 out_valid,
  output hsbr_pkg::hsbr_out_t  out_pixel
);
  import hsbr_pkg::*;

  localparam int unsigned F = FRACTION_BITS;

  logic                prep_vld;
  logic [F+2:0]        prep_h6;
  logic [F:0]          prep_s;
  logic [F:0]          prep_b;
  logic [NUM_CHAN-1:0] chan_vld;
  logic [7:0]          chan_value [NUM_CHAN];

  assign busy = 1'b0;

  hsbr_prep #(
    .FRACTION_BITS(F)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_pixel (in_pixel),
    .vld      (prep_vld),
    .h6       (prep_h6),
    .s        (prep_s),
    .b        (prep_b)
  );

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_chan
    hsbr_chan #(
      .FRACTION_BITS(F)
    ) u_chan (
      .clk    (clk),
      .rst_n  (rst_n),
      .offset (CHAN_OFFSET[k]),
      .in_vld (prep_vld),
      .h6     (prep_h6),
      .s      (prep_s),
      .b      (prep_b),
      .vld    (chan_vld[k]),
      .value  (chan_value[k])
    );
  end

  assign out_valid       = chan_vld[0];
  assign out_pixel.red   = chan_value[0];
  assign out_pixel.green = chan_value[1];
  assign out_pixel.blue  = chan_value[2];

  // The three channel pipelines must stay in lockstep.
  a_chan_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (chan_vld == '0) || (chan_vld == '1))
    else $error("channel valid bits disagree");

  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(prep_vld, 6))
    else $error("result strobe without a matching input beat");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (prep_vld && (prep_b == '0)) |-> ##6 (out_pixel == '0))
    else $error("zero brightness did not give black");

  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (prep_vld && (prep_s == '0)) |-> ##6
      ((out_pixel.red == out_pixel.green) && (out_pixel.green == out_pixel.blue)))
    else $error("zero saturation did not give gray");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// HSB to RGB converter testbench
// Sends pixel beats to hsb_to_rgb_smooth_top and checks every result beat
// against typed colors or an in-bench fixed-point predictor. A directed
// table covers the field extremes and corner colors; then come random pixels,
// with random idle gaps on the input side and runs without gaps.
// ----------------------------------------------------------------------------
module tb;
  import hsbr_pkg::*;

  localparam int unsigned FRAC       = 12;
  localparam int unsigned NUM_RANDOM = 1330;
  localparam int unsigned IDLE_LIMIT = 200;
  localparam int unsigned MAX_SHOWN  = 10;

  typedef struct {
    hsbr_in_t  pixel;
    bit        typed;
    hsbr_out_t rgb;
  } pixel_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  hsbr_in_t  in_pixel;
  logic      out_valid;
  hsbr_out_t out_pixel;

  hsbr_out_t   rgb_expect_q[$];
  pixel_row_t  pixel_table[$];
  int unsigned mismatch_cnt;
  int unsigned idle_cycles;

  hsb_to_rgb_smooth_top #(.FRACTION_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Saturation and brightness clip at 1.0 before they enter the datapath.
  function automatic logic [63:0] unit_level(input logic [12:0] v);
    logic [63:0] w;
    w = (v > IN_ONE) ? 64'(IN_ONE) : 64'(v);
    return (w << FRAC) >> IN_FRAC;
  endfunction

  function automatic logic [7:0] channel_level(input logic [63:0] h6,
                                               input logic [2:0]  offset,
                                               input logic [63:0] s,
                                               input logic [63:0] b);
    logic [63:0] one, t, d, x, x2, y, m, v;
    one = 64'd1 << FRAC;
    t = h6 + 64'(offset) * one;
    while (t >= 6 * one) t = t - 6 * one;
    d = (t >= 3 * one) ? t - 3 * one : 3 * one - t;
    x = (d <= one) ? 64'd0 : d - one;
    if (x > one) x = one;
    // Smoothstep x*x*(3-2x), each product truncated to the fraction width.
    x2 = (x * x) >> FRAC;
    y  = (x2 * (3 * one - 2 * x)) >> FRAC;
    m  = (one - s) + ((s * y) >> FRAC);
    v  = (m * b) >> FRAC;
    if (v > one) v = one;
    v = (v * 255) >> FRAC;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic hsbr_out_t predict_rgb(input hsbr_in_t p);
    hsbr_out_t   c;
    logic [63:0] h6, s, b;
    h6 = ((64'(p.hue) * 6) << FRAC) >> IN_FRAC;
    s  = unit_level(p.saturation);
    b  = unit_level(p.brightness);
    c.red   = channel_level(h6, CHAN_OFFSET[0], s, b);
    c.green = channel_level(h6, CHAN_OFFSET[1], s, b);
    c.blue  = channel_level(h6, CHAN_OFFSET[2], s, b);
    return c;
  endfunction

  task automatic add_row(input logic [11:0] h, input logic [12:0] s,
                         input logic [12:0] b, input bit typed,
                         input logic [7:0] r, input logic [7:0] g,
                         input logic [7:0] bl);
    pixel_row_t row;
    row.pixel.hue        = h;
    row.pixel.saturation = s;
    row.pixel.brightness = b;
    row.typed            = typed;
    row.rgb.red          = r;
    row.rgb.green        = g;
    row.rgb.blue         = bl;
    pixel_table.push_back(row);
  endtask

  function automatic logic [12:0] random_unit();
    case ($urandom_range(0, 9))
      0:       return 13'd0;
      1:       return IN_ONE;
      2:       return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(0, 4096));
    endcase
  endfunction

  // Presents one beat, holds it until taken, then records its expected colors.
  task automatic send_pixel(input hsbr_in_t p, input hsbr_out_t rgb, input int gap);
    if (gap > 0) begin
      start    <= 1'b0;
      in_pixel <= hsbr_in_t'($urandom());
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (busy);
    rgb_expect_q.push_back(rgb);
  endtask

  // Result checker and watchdog.
  always @(posedge clk) begin
    hsbr_out_t want;
    if (rst_n && out_valid) begin
      if (rgb_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
          $display("unexpected result beat: r=%0d g=%0d b=%0d",
                   out_pixel.red, out_pixel.green, out_pixel.blue);
      end else begin
        want = rgb_expect_q.pop_front();
        if (out_pixel.red !== want.red || out_pixel.green !== want.green ||
            out_pixel.blue !== want.blue) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("rgb mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     want.red, want.green, want.blue,
                     out_pixel.red, out_pixel.green, out_pixel.blue);
        end
      end
    end
    if ((start && !busy) || out_valid) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    hsbr_in_t  p;
    hsbr_out_t rgb;
    bit        no_gaps;
    int        gap;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_pixel     = '0;

    // Directed corner colors; typed results are easy to read off by hand.
    add_row(12'd0,    13'd0,    13'd0,    1, 8'd0,   8'd0,   8'd0);
    add_row(12'd0,    13'd0,    13'd4096, 1, 8'd255, 8'd255, 8'd255);
    add_row(12'd4095, 13'd0,    13'd4096, 1, 8'd255, 8'd255, 8'd255);
    add_row(12'd0,    13'd4096, 13'd4096, 1, 8'd255, 8'd0,   8'd0);
    add_row(12'd0,    13'd8191, 13'd8191, 1, 8'd255, 8'd0,   8'd0);
    add_row(12'd2048, 13'd4096, 13'd4096, 1, 8'd0,   8'd255, 8'd255);
    add_row(12'd0,    13'd2048, 13'd4096, 1, 8'd255, 8'd127, 8'd127);
    add_row(12'd0,    13'd0,    13'd2048, 1, 8'd127, 8'd127, 8'd127);
    add_row(12'd0,    13'd4096, 13'd4095, 1, 8'd254, 8'd0,   8'd0);
    add_row(12'd1234, 13'd8191, 13'd0,    1, 8'd0,   8'd0,   8'd0);
    add_row(12'd4095, 13'd8191, 13'd8191, 0, 8'd0,   8'd0,   8'd0);
    add_row(12'd4095, 13'd4096, 13'd4096, 0, 8'd0,   8'd0,   8'd0);
    add_row(12'd1,    13'd4096, 13'd4096, 0, 8'd0,   8'd0,   8'd0);
    add_row(12'd683,  13'd4096, 13'd4096, 0, 8'd0,   8'd0,   8'd0);
    add_row(12'd1365, 13'd4096, 13'd4096, 0, 8'd0,   8'd0,   8'd0);
    add_row(12'd2047, 13'd4097, 13'd4096, 0, 8'd0,   8'd0,   8'd0);
    add_row(12'd2049, 13'd4096, 13'd4097, 0, 8'd0,   8'd0,   8'd0);
    add_row(12'd2731, 13'd3000, 13'd4095, 0, 8'd0,   8'd0,   8'd0);
    add_row(12'd3413, 13'd1,    13'd1,    0, 8'd0,   8'd0,   8'd0);
    add_row(12'd2730, 13'd4095, 13'd6000, 0, 8'd0,   8'd0,   8'd0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (pixel_table[i]) begin
      rgb = pixel_table[i].typed ? pixel_table[i].rgb : predict_rgb(pixel_table[i].pixel);
      send_pixel(pixel_table[i].pixel, rgb, $urandom_range(0, 6));
    end

    // Random pixels; every so often switch between gapped traffic and a run
    // of back-to-back beats.
    no_gaps = 1'b0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      p.hue        = 12'($urandom());
      p.saturation = random_unit();
      p.brightness = random_unit();
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      send_pixel(p, predict_rgb(p), gap);
    end
    start <= 1'b0;

    while (rgb_expect_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
